// ----- src/apl_pkg.sv -----
// ----------------------------------------------------------------------------
// apl_pkg
// Shared types and constants for the positional array list core.
// ----------------------------------------------------------------------------
package apl_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Field widths of the request and result
  localparam int OP_W   = 3;
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int STS_W  = 2;
  localparam int OCNT_W = 5;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_MID   = 3'd1,
    OP_INS_END   = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_READ      = 3'd4
  } apl_op_t;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } apl_status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_HOLD
  } apl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
  } apl_cmd_t;

endpackage

// ----- src/apl_req_if.sv -----
// ----------------------------------------------------------------------------
// apl_req_if
// Request channel: operation, value and position with valid/ready.
// ----------------------------------------------------------------------------
interface apl_req_if;
  logic                       valid;
  logic                       ready;
  logic [apl_pkg::OP_W-1:0]   operation;
  logic [apl_pkg::WORD_W-1:0] value;
  logic [apl_pkg::POS_W-1:0]  position;

  modport source (output valid, operation, value, position, input ready);
  modport sink   (input valid, operation, value, position, output ready);
endinterface

// ----- src/apl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// apl_rsp_if
// Result channel: status, count and read word with valid/ready.
// ----------------------------------------------------------------------------
interface apl_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [apl_pkg::STS_W-1:0]  status;
  logic [apl_pkg::OCNT_W-1:0] count;
  logic [apl_pkg::WORD_W-1:0] read_value;

  modport source (output valid, status, count, read_value, input ready);
  modport sink   (input valid, status, count, read_value, output ready);
endinterface

// ----- src/apl_ctrl.sv -----
// ----------------------------------------------------------------------------
// apl_ctrl
// Handshake controller: tracks whether a result is held and issues the
// load command to the datapath when a request is taken.
// ----------------------------------------------------------------------------
module apl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output apl_pkg::apl_cmd_t cmd
);

  apl_pkg::apl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    unique case (state_r)
      apl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = apl_pkg::S_HOLD;
        end
      end
      apl_pkg::S_HOLD: begin
        // result slot frees as it is taken, so a new request may enter
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
          end else begin
            state_nxt = apl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = apl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/apl_dpath.sv -----
// ----------------------------------------------------------------------------
// apl_dpath
// List datapath: a row of word cells that shift up or down in parallel,
// the entry count and the result registers.
// ----------------------------------------------------------------------------
module apl_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apl_pkg::apl_cmd_t          cmd,
  input  logic [apl_pkg::OP_W-1:0]   operation,
  input  logic [apl_pkg::WORD_W-1:0] value,
  input  logic [apl_pkg::POS_W-1:0]  position,
  output logic [apl_pkg::STS_W-1:0]  status,
  output logic [apl_pkg::OCNT_W-1:0] count,
  output logic [apl_pkg::WORD_W-1:0] read_value
);

  localparam int CAP   = apl_pkg::CAPACITY;
  localparam int CNT_W = apl_pkg::CNT_W;
  localparam int IDX_W = apl_pkg::IDX_W;

  logic [apl_pkg::WORD_W-1:0] entries_r [CAP];
  logic [apl_pkg::WORD_W-1:0] ent_nxt   [CAP];
  logic [CNT_W-1:0]           count_r, count_nxt;
  apl_pkg::apl_status_t       status_r, status_nxt;
  logic [apl_pkg::WORD_W-1:0] rdata_r, rdata_nxt;

  logic             ins, rem, pos_ok;
  logic [CNT_W-1:0] slot, pos_c, rem_idx;

  // Position widened to count width, zero-based entry index
  assign pos_c   = CNT_W'(position);
  assign rem_idx = pos_c - CNT_W'(1);
  assign pos_ok  = (pos_c != '0) && (pos_c <= count_r)
                && (position <= apl_pkg::POS_W'(CAP));

  // Request decode
  always_comb begin
    ins        = 1'b0;
    rem        = 1'b0;
    slot       = '0;
    status_nxt = apl_pkg::ST_OK;
    rdata_nxt  = '0;
    count_nxt  = count_r;
    unique case (apl_pkg::apl_op_t'(operation)) inside
      apl_pkg::OP_INS_FRONT, apl_pkg::OP_INS_MID, apl_pkg::OP_INS_END: begin
        if (count_r >= apl_pkg::CAP_CNT) begin
          status_nxt = apl_pkg::ST_FULL;
        end else begin
          ins       = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
        if (apl_pkg::apl_op_t'(operation) == apl_pkg::OP_INS_MID) begin
          // half the count; a single entry puts the new word behind it
          slot = (count_r == CNT_W'(1)) ? CNT_W'(1) : (count_r >> 1);
        end else if (apl_pkg::apl_op_t'(operation) == apl_pkg::OP_INS_END) begin
          slot = count_r;
        end
      end
      apl_pkg::OP_REMOVE: begin
        if (!pos_ok) begin
          status_nxt = apl_pkg::ST_BADPOS;
        end else begin
          rem       = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      apl_pkg::OP_READ: begin
        if (!pos_ok) begin
          status_nxt = apl_pkg::ST_BADPOS;
        end else begin
          rdata_nxt = entries_r[rem_idx[IDX_W-1:0]];
        end
      end
      default: begin
        status_nxt = apl_pkg::ST_BADPOS;
      end
    endcase
  end

  // Cell row: each cell takes the new word, its lower or its upper neighbour
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam logic [CNT_W-1:0] I = CNT_W'(i);
    always_comb begin
      ent_nxt[i] = entries_r[i];
      if (ins && (I == slot)) begin
        ent_nxt[i] = value;
      end else if (ins && (I > slot)) begin
        ent_nxt[i] = entries_r[(i > 0) ? i - 1 : 0];
      end else if (rem && (I >= rem_idx) && (i < CAP - 1)) begin
        ent_nxt[i] = entries_r[(i < CAP - 1) ? i + 1 : i];
      end
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < CAP; k++) begin
        entries_r[k] <= ent_nxt[k];
      end
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load) begin
      count_r <= count_nxt;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= status_nxt;
      rdata_r  <= rdata_nxt;
    end
  end

  assign status     = status_r;
  assign count      = apl_pkg::OCNT_W'(count_r);
  assign read_value = rdata_r;

endmodule

// ----- src/positional_array_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_array_list_core
// Fixed-capacity ordered word list with front, middle and end insert,
// positional remove and positional read.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle with out_ready high; one result register
// is the limit, and a request enters in the cycle the prior result is taken.
// Reset (synchronous, rst_n low): entry count cleared, no result held.
// Stored words are not cleared; only entries below the count are ever read.
module positional_array_list_core (
  input logic       clk,
  input logic       rst_n,
  apl_req_if.sink   in_ch,
  apl_rsp_if.source out_ch
);

  apl_pkg::apl_cmd_t cmd;

  // Handshake control
  apl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // List storage and result
  apl_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .operation  (in_ch.operation),
    .value      (in_ch.value),
    .position   (in_ch.position),
    .status     (out_ch.status),
    .count      (out_ch.count),
    .read_value (out_ch.read_value)
  );

endmodule

// ----- tb/sv/apl_list_monitor.sv -----
// ----------------------------------------------------------------------------
// apl_list_monitor
// Watches the request and result channels of the positional array list
// core. It keeps its own copy of the list, works out the result of each
// accepted request and compares every accepted result with the oldest one
// still owed. It reports the failure count, the number of results still
// owed and the predicted list length to the testbench top.
// ----------------------------------------------------------------------------
module apl_list_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  logic [apl_pkg::OP_W-1:0]   req_operation,
  input  logic [apl_pkg::WORD_W-1:0] req_value,
  input  logic [apl_pkg::POS_W-1:0]  req_position,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  logic [apl_pkg::STS_W-1:0]  rsp_status,
  input  logic [apl_pkg::OCNT_W-1:0] rsp_count,
  input  logic [apl_pkg::WORD_W-1:0] rsp_read_value,
  output int                         fail_count,
  output int                         owed_count,
  output int                         list_len
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    apl_pkg::apl_status_t       status;
    logic [apl_pkg::OCNT_W-1:0] count;
    logic [apl_pkg::WORD_W-1:0] read_value;
  } list_result_t;

  // Shadow copy of the list
  logic [apl_pkg::WORD_W-1:0] list_words [apl_pkg::CAPACITY];
  int                         held;
  list_result_t               owed_results [$];

  initial begin
    fail_count = 0;
    owed_count = 0;
    list_len   = 0;
    held       = 0;
    foreach (list_words[i]) list_words[i] = '0;
  end

  // Apply one request to the shadow list and return the result it owes
  function automatic list_result_t apply_request(
    input logic [apl_pkg::OP_W-1:0]   op,
    input logic [apl_pkg::WORD_W-1:0] word,
    input logic [apl_pkg::POS_W-1:0]  pos
  );
    list_result_t res;
    int           slot;
    int           k;
    res        = '0;
    res.status = apl_pkg::ST_OK;
    case (op) inside
      apl_pkg::OP_INS_FRONT, apl_pkg::OP_INS_MID, apl_pkg::OP_INS_END: begin
        if (held >= apl_pkg::CAPACITY) begin
          res.status = apl_pkg::ST_FULL;
        end else begin
          if (op == apl_pkg::OP_INS_FRONT) begin
            slot = 0;
          end else if (op == apl_pkg::OP_INS_MID) begin
            // middle slot is count/2, but never slot 0 of a non-empty list
            slot = held / 2;
            if (slot == 0 && held != 0) slot = 1;
          end else begin
            slot = held;
          end
          for (k = held; k > slot; k--) list_words[k] = list_words[k-1];
          list_words[slot] = word;
          held++;
        end
      end
      apl_pkg::OP_REMOVE, apl_pkg::OP_READ: begin
        if (pos < 1 || pos > held) begin
          res.status = apl_pkg::ST_BADPOS;
        end else if (op == apl_pkg::OP_REMOVE) begin
          for (k = pos - 1; k + 1 < held; k++) list_words[k] = list_words[k+1];
          held--;
        end else begin
          res.read_value = list_words[pos-1];
        end
      end
      default: begin
        // unused operation codes leave the list alone
        res.status = apl_pkg::ST_BADPOS;
      end
    endcase
    res.count = apl_pkg::OCNT_W'(held);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    list_result_t owed;
    if (rst_n) begin
      if (rsp_valid && rsp_ready) begin
        if (owed_results.size() == 0) begin
          note_failure($sformatf("result with no request owed: status %0d count %0d data %h",
                                 rsp_status, rsp_count, rsp_read_value));
        end else begin
          owed = owed_results.pop_front();
          if (rsp_status !== owed.status || rsp_count !== owed.count ||
              rsp_read_value !== owed.read_value) begin
            note_failure($sformatf({"expected status %0d count %0d data %h, ",
                                    "got status %0d count %0d data %h"},
                                   owed.status, owed.count, owed.read_value,
                                   rsp_status, rsp_count, rsp_read_value));
          end
        end
      end
      if (req_valid && req_ready) begin
        owed_results.push_back(apply_request(req_operation, req_value, req_position));
      end
      owed_count = owed_results.size();
      list_len   = held;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the positional array list core. A short directed
// run covers the empty-list middle insert, the one-entry middle insert,
// out-of-range positions and unused operation codes; phases of random
// requests then fill, churn and drain the list, reaching the full case
// repeatedly, under random and absent idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_LEN    = 50;
  localparam int MAX_WAIT     = 18;
  localparam int OP_CODE_MAX  = (1 << apl_pkg::OP_W) - 1;
  localparam int OP_W         = apl_pkg::OP_W;
  localparam int WORD_W       = apl_pkg::WORD_W;
  localparam int POS_W        = apl_pkg::POS_W;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} list_phase_t;
  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  logic       clk;
  logic       rst_n;
  int         fail_count;
  int         owed_count;
  int         list_len;
  idle_mode_t idle_mode;

  apl_req_if req_ch ();
  apl_rsp_if rsp_ch ();

  positional_array_list_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  apl_list_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_ch.valid),
    .req_ready      (req_ch.ready),
    .req_operation  (req_ch.operation),
    .req_value      (req_ch.value),
    .req_position   (req_ch.position),
    .rsp_valid      (rsp_ch.valid),
    .rsp_ready      (rsp_ch.ready),
    .rsp_status     (rsp_ch.status),
    .rsp_count      (rsp_ch.count),
    .rsp_read_value (rsp_ch.read_value),
    .fail_count     (fail_count),
    .owed_count     (owed_count),
    .list_len       (list_len)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Idle cycles before a request or between results
  function automatic int draw_wait();
    case (idle_mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
      default:     return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Mostly in-range positions, some just outside, a few anywhere
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
    if (r == 8) return $urandom_range(0, 1) ? POS_W'(0) : POS_W'(list_len + 1);
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input list_phase_t ph);
    int r;
    int ins_share;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_W'($urandom_range(apl_pkg::OP_READ + 1, OP_CODE_MAX));
    ins_share = (ph == PH_FILL) ? 75 : (ph == PH_DRAIN) ? 15 : 40;
    r = $urandom_range(0, 99);
    if (r < ins_share) begin
      return OP_W'($urandom_range(apl_pkg::OP_INS_FRONT, apl_pkg::OP_INS_END));
    end
    return ($urandom_range(0, 99) < 65) ? apl_pkg::OP_REMOVE : apl_pkg::OP_READ;
  endfunction

  // Offer one request and hold it until taken; returns at a falling edge
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [WORD_W-1:0] word,
                              input logic [POS_W-1:0]  pos);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= word;
    req_ch.position  <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every owed result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
  endtask

  // Result side: random stall after each taken result
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    list_phase_t phase_order [4];
    list_phase_t ph;
    phase_order = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_MIXED};
    ph                = PH_FILL;
    idle_mode         = IDLE_FULL;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = apl_pkg::OP_INS_FRONT;
    req_ch.value      = '0;
    req_ch.position   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, middle slot edge cases, bad positions, unused codes
    send_request(apl_pkg::OP_READ,      '0,            POS_W'(1));
    send_request(apl_pkg::OP_REMOVE,    '0,            POS_W'(0));
    send_request(apl_pkg::OP_INS_MID,   '0,            POS_W'(0));
    send_request(apl_pkg::OP_INS_MID,   '1,            POS_W'(0));
    send_request(apl_pkg::OP_INS_FRONT, 32'hA5A5_A5A5, POS_W'(0));
    send_request(apl_pkg::OP_INS_END,   32'h5A5A_5A5A, POS_W'(0));
    send_request(apl_pkg::OP_INS_MID,   32'h0000_1234, POS_W'(0));
    send_request(apl_pkg::OP_READ,      '0,            POS_W'(1));
    send_request(apl_pkg::OP_READ,      '0,            POS_W'(5));
    send_request(apl_pkg::OP_READ,      '0,            POS_W'(6));
    send_request(apl_pkg::OP_READ,      '0,            POS_W'(31));
    for (int c = apl_pkg::OP_READ + 1; c <= OP_CODE_MAX; c++) begin
      send_request(OP_W'(c), '1, POS_W'(16));
    end
    send_request(apl_pkg::OP_REMOVE,    '0,            POS_W'(5));
    send_request(apl_pkg::OP_REMOVE,    '0,            POS_W'(1));
    send_request(apl_pkg::OP_REMOVE,    '0,            POS_W'(0));
    send_request(apl_pkg::OP_READ,      '0,            POS_W'(16));
    drain_results();

    // Random phases: fill to full, churn, drain, churn, under varied idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        ph        = phase_order[(n / PHASE_LEN) % 4];
        idle_mode = idle_mode_t'((n / PHASE_LEN) % 3);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_request(pick_op(ph), pick_word(), pick_position());
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_array_list_core test passed");
    end else begin
      $display("positional_array_list_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("positional_array_list_core test failed");
    $finish;
  end

endmodule
